FILE: sv/jdbh_pkg.sv
// ----------------------------------------------------------------------------
// jdbh_pkg
// shared types, codes and constants of the joystick direction / button hold
// block
// ----------------------------------------------------------------------------
package jdbh_pkg;

    // width of the stored press stamps and of the hold difference
    localparam int TIME_BITS = 32;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEADZONE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_TIME = 1'b1;

    localparam logic [7:0] DEADZONE_RESET = 8'd20;
    localparam logic [15:0] HOLD_TIME_RESET = 16'd1000;

    typedef enum logic [2:0] {
        DIR_CENTER = 3'd0,
        DIR_UP     = 3'd1,
        DIR_DOWN   = 3'd2,
        DIR_LEFT   = 3'd3,
        DIR_RIGHT  = 3'd4
    } dir_t;

    typedef enum logic [1:0] {
        COMBO_NONE = 2'd0,
        COMBO_C    = 2'd1,
        COMBO_Z    = 2'd2,
        COMBO_BOTH = 2'd3
    } combo_t;

    typedef struct packed {
        logic signed [7:0] stick_x;
        logic signed [7:0] stick_y;
        logic              c_button;
        logic              z_button;
        logic [31:0]       time_ms;
    } sample_t;

    typedef struct packed {
        logic c_new;
        logic c_released;
        logic c_held;
        logic z_new;
        logic z_released;
        logic z_held;
        logic both_new;
        logic both_released;
        logic both_held;
    } btn_flags_t;

    typedef struct packed {
        dir_t   direction;
        combo_t button_combo;
        logic   c_new;
        logic   c_released;
        logic   c_held;
        logic   z_new;
        logic   z_released;
        logic   z_held;
        logic   both_new;
        logic   both_released;
        logic   both_held;
    } result_t;

endpackage

FILE: sv/jdbh_dir.sv
// ----------------------------------------------------------------------------
// jdbh_dir
// stick direction classifier with deadzone and dominant-axis rule
// ----------------------------------------------------------------------------
module jdbh_dir
    import jdbh_pkg::*;
(
    input  logic signed [7:0] stick_x,
    input  logic signed [7:0] stick_y,
    input  logic [7:0]        deadzone,
    output dir_t              direction
);

    logic [7:0]        ax;
    logic [7:0]        ay;
    logic signed [9:0] xs;
    logic signed [9:0] ys;
    logic signed [9:0] dz_pos;
    logic signed [9:0] dz_neg;
    logic              y_wins;
    logic              x_wins;

    always_comb
    begin
        // magnitude of -128 is 128, still fits 8 bits unsigned
        ax     = stick_x[7] ? 8'(-stick_x) : 8'(stick_x);
        ay     = stick_y[7] ? 8'(-stick_y) : 8'(stick_y);
        xs     = 10'(stick_x);
        ys     = 10'(stick_y);
        dz_pos = $signed({2'b00, deadzone});
        dz_neg = -dz_pos;
        y_wins = ay > ax;
        x_wins = ax > ay;

        if (ys >= dz_pos && y_wins)
            direction = DIR_UP;
        else if (ys <= dz_neg && y_wins)
            direction = DIR_DOWN;
        else if (xs <= dz_neg && x_wins)
            direction = DIR_LEFT;
        else if (xs >= dz_pos && x_wins)
            direction = DIR_RIGHT;
        else
            direction = DIR_CENTER;
    end

endmodule

FILE: sv/jdbh_btn.sv
// ----------------------------------------------------------------------------
// jdbh_btn
// button combination edge tracking and press stamp hold detection
// ----------------------------------------------------------------------------
module jdbh_btn
    import jdbh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  combo_t               cur,
    input  logic [TIME_BITS-1:0] now,
    input  logic [15:0]          hold_time_ms,
    output btn_flags_t           flags
);

    combo_t               prev_reg;
    logic [TIME_BITS-1:0] c_stamp_reg;
    logic [TIME_BITS-1:0] z_stamp_reg;
    logic [TIME_BITS-1:0] both_stamp_reg;
    logic [TIME_BITS-1:0] c_stamp_next;
    logic [TIME_BITS-1:0] z_stamp_next;
    logic [TIME_BITS-1:0] both_stamp_next;
    logic [TIME_BITS-1:0] hold_ext;

    function automatic logic held(input logic [TIME_BITS-1:0] stamp,
                                  input logic [TIME_BITS-1:0] t,
                                  input logic [TIME_BITS-1:0] limit);
        logic [TIME_BITS-1:0] diff;
        begin
            diff = t - stamp;
            held = (stamp != '0) && (diff > limit);
        end
    endfunction

    always_comb
    begin
        hold_ext = TIME_BITS'(hold_time_ms);

        flags.c_new         = (cur == COMBO_C) && (prev_reg != COMBO_C);
        flags.c_released    = (cur != COMBO_C) && (prev_reg == COMBO_C);
        flags.z_new         = (cur == COMBO_Z) && (prev_reg != COMBO_Z);
        flags.z_released    = (cur != COMBO_Z) && (prev_reg == COMBO_Z);
        flags.both_new      = (cur == COMBO_BOTH) && (prev_reg != COMBO_BOTH);
        flags.both_released = (cur != COMBO_BOTH) && (prev_reg == COMBO_BOTH);

        c_stamp_next = c_stamp_reg;
        if (flags.c_new)
            c_stamp_next = now;
        if (flags.c_released)
            c_stamp_next = '0;

        z_stamp_next = z_stamp_reg;
        if (flags.z_new)
            z_stamp_next = now;
        if (flags.z_released)
            z_stamp_next = '0;

        both_stamp_next = both_stamp_reg;
        if (flags.both_new)
            both_stamp_next = now;
        if (cur != COMBO_BOTH)
            both_stamp_next = '0;

        // held is judged on the updated stamps
        flags.c_held    = held(c_stamp_next, now, hold_ext);
        flags.z_held    = held(z_stamp_next, now, hold_ext);
        flags.both_held = held(both_stamp_next, now, hold_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= COMBO_NONE;
            c_stamp_reg    <= '0;
            z_stamp_reg    <= '0;
            both_stamp_reg <= '0;
        end
        else if (advance)
        begin
            prev_reg       <= cur;
            c_stamp_reg    <= c_stamp_next;
            z_stamp_reg    <= z_stamp_next;
            both_stamp_reg <= both_stamp_next;
        end
    end

endmodule

FILE: sv/joystick_direction_button_hold_core.sv
// ----------------------------------------------------------------------------
// joystick_direction_button_hold_core
// controller sample classifier: stick direction and button hold detection
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid / in_ready carry one sample_t request (stick x/y,
//   C and Z levels, millisecond stamp); out channel: out_valid / out_ready
//   carry one result_t request per sample, in order
//   cfg port: cfg_we with cfg_index / cfg_data writes deadzone (index 0)
//   or hold_time_ms (index 1) in one cycle; write only while idle
//   latency: a sample accepted at edge n shows its result after edge n+1
//   throughput: one sample per cycle; the input register feeds a single
//   pass of compare and subtract logic into the result register
//   the press state (previous combo and stamps) updates only when a sample
//   moves from the input register into the result register
//   stall: while out_ready is low the result holds, the input register
//   still fills, then in_ready drops until the result drains
//   reset: empty pipeline, deadzone 20, hold time 1000 ms, all stamps zero
//   (zero stamp means not pressed)
// ----------------------------------------------------------------------------
module joystick_direction_button_hold_core
    import jdbh_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  sample_t                  in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output result_t                  out_data,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    // configuration registers
    logic [7:0]  deadzone_reg;
    logic [15:0] hold_time_reg;

    // input stage
    logic    s1_valid_reg;
    sample_t s1_data_reg;

    // result stage
    logic    out_valid_reg;
    result_t out_data_reg;

    logic                 advance;
    combo_t               cur_combo;
    logic [63:0]          time_wide;
    logic [TIME_BITS-1:0] now;
    dir_t                 dir;
    btn_flags_t           flags;
    result_t              result_next;

    // result stage takes a new sample when empty or being drained
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        cur_combo = combo_t'({s1_data_reg.z_button, s1_data_reg.c_button});
        // stamp width may be narrower or wider than the port field
        time_wide = {32'b0, s1_data_reg.time_ms};
        now       = time_wide[TIME_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg  <= DEADZONE_RESET;
            hold_time_reg <= HOLD_TIME_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEADZONE:  deadzone_reg  <= cfg_data[7:0];
                CFG_HOLD_TIME: hold_time_reg <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    jdbh_dir u_dir (
        .stick_x   (s1_data_reg.stick_x),
        .stick_y   (s1_data_reg.stick_y),
        .deadzone  (deadzone_reg),
        .direction (dir)
    );

    jdbh_btn u_btn (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .cur          (cur_combo),
        .now          (now),
        .hold_time_ms (hold_time_reg),
        .flags        (flags)
    );

    always_comb
    begin
        result_next.direction     = dir;
        result_next.button_combo  = cur_combo;
        result_next.c_new         = flags.c_new;
        result_next.c_released    = flags.c_released;
        result_next.c_held        = flags.c_held;
        result_next.z_new         = flags.z_new;
        result_next.z_released    = flags.z_released;
        result_next.z_held        = flags.z_held;
        result_next.both_new      = flags.both_new;
        result_next.both_released = flags.both_released;
        result_next.both_held     = flags.both_held;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_data_reg <= in_data;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result_next;
    end

endmodule

FILE: dv/jdbh_result_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jdbh_result_check
// watches the sample and result channels of the joystick core, predicts each
// result from its own copy of the press state and compares field by field
// ----------------------------------------------------------------------------
module jdbh_result_check
    import jdbh_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  sample_t                  in_data,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  result_t                  out_data,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       errors,
    output int                       pending
);

    logic [7:0]           dz_reg;
    logic [15:0]          hold_reg;
    combo_t               last_combo;
    logic [TIME_BITS-1:0] c_stamp;
    logic [TIME_BITS-1:0] z_stamp;
    logic [TIME_BITS-1:0] both_stamp;
    result_t              expected_q[$];

    // zero stamp reads as not pressed
    function automatic logic held_since(input logic [TIME_BITS-1:0] stamp,
                                        input logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] span;
        span = now - stamp;
        return (stamp != '0) && (span > hold_reg);
    endfunction

    // direction and combo flags for one sample, advances the press state
    function automatic result_t classify(input sample_t s);
        result_t              r;
        int                   x;
        int                   y;
        int                   ax;
        int                   ay;
        int                   dz;
        combo_t               cur;
        logic [TIME_BITS-1:0] now;
        x = $signed(s.stick_x);
        y = $signed(s.stick_y);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        dz = int'(dz_reg);
        cur = combo_t'({s.z_button, s.c_button});
        now = s.time_ms;
        r = '0;
        if (y >= dz && ay > ax)
            r.direction = DIR_UP;
        else if (y <= -dz && ay > ax)
            r.direction = DIR_DOWN;
        else if (x <= -dz && ax > ay)
            r.direction = DIR_LEFT;
        else if (x >= dz && x > ay)
            r.direction = DIR_RIGHT;
        else
            r.direction = DIR_CENTER;
        r.button_combo = cur;
        r.c_new = (cur == COMBO_C) && (last_combo != COMBO_C);
        r.c_released = (cur != COMBO_C) && (last_combo == COMBO_C);
        r.z_new = (cur == COMBO_Z) && (last_combo != COMBO_Z);
        r.z_released = (cur != COMBO_Z) && (last_combo == COMBO_Z);
        r.both_new = (cur == COMBO_BOTH) && (last_combo != COMBO_BOTH);
        r.both_released = (cur != COMBO_BOTH) && (last_combo == COMBO_BOTH);
        if (r.c_new)
            c_stamp = now;
        if (r.z_new)
            z_stamp = now;
        if (r.both_new)
            both_stamp = now;
        if (r.c_released)
            c_stamp = '0;
        if (r.z_released)
            z_stamp = '0;
        if (cur != COMBO_BOTH)
            both_stamp = '0;
        last_combo = cur;
        r.c_held = held_since(c_stamp, now);
        r.z_held = held_since(z_stamp, now);
        r.both_held = held_since(both_stamp, now);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        logic    bad;
        if (!rst_n)
        begin
            dz_reg = DEADZONE_RESET;
            hold_reg = HOLD_TIME_RESET;
            last_combo = COMBO_NONE;
            c_stamp = '0;
            z_stamp = '0;
            both_stamp = '0;
            expected_q.delete();
            errors = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result request: %h", out_data);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    bad = (out_data.direction !== exp_r.direction)
                        || (out_data.button_combo !== exp_r.button_combo)
                        || (out_data.c_new !== exp_r.c_new)
                        || (out_data.c_released !== exp_r.c_released)
                        || (out_data.c_held !== exp_r.c_held)
                        || (out_data.z_new !== exp_r.z_new)
                        || (out_data.z_released !== exp_r.z_released)
                        || (out_data.z_held !== exp_r.z_held)
                        || (out_data.both_new !== exp_r.both_new)
                        || (out_data.both_released !== exp_r.both_released)
                        || (out_data.both_held !== exp_r.both_held);
                    if (bad)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: dir %0d/%0d combo %0d/%0d flags %b/%b",
                                     exp_r.direction, out_data.direction,
                                     exp_r.button_combo, out_data.button_combo,
                                     exp_r[8:0], out_data[8:0]);
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_DEADZONE)
                    dz_reg = cfg_data[7:0];
                else if (cfg_index == CFG_HOLD_TIME)
                    hold_reg = cfg_data[15:0];
            end
            if (in_valid && in_ready)
                expected_q.push_back(classify(in_data));
        end
        pending = expected_q.size();
    end

endmodule

FILE: dv/tb_joystick_direction_button_hold_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_joystick_direction_button_hold_core
// drives controller sample requests with random gaps and back pressure,
// walks the deadzone and hold time through their extremes, and gives the
// verdict from the failure and pending counts of the result checker
// ----------------------------------------------------------------------------
module tb_joystick_direction_button_hold_core;
    import jdbh_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    sample_t                  in_data;
    logic                     out_valid;
    logic                     out_ready;
    result_t                  out_data;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int                       errors;
    int                       pending;

    // stimulus shaping state
    logic [31:0] sample_clock;
    combo_t      held_combo;
    logic [7:0]  dz_cfg;
    logic [15:0] hold_cfg;
    bit          source_steady;
    bit          sink_steady;
    bit          hold_req;

    joystick_direction_button_hold_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    jdbh_result_check u_result_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic sample_t mk(input int x, input int y, input bit c, input bit z,
                                   input logic [31:0] t);
        sample_t s;
        s.stick_x = 8'(x);
        s.stick_y = 8'(y);
        s.c_button = c;
        s.z_button = z;
        s.time_ms = t;
        return s;
    endfunction

    // well-formed samples: stamps move forward around the hold time, combos
    // stay put for a few samples, stick sits near the deadzone, on ties or
    // at the rails; noisy samples are fully random
    function automatic sample_t next_sample(input bit noisy);
        sample_t s;
        int      m;
        int      a;
        int      b;
        int      t;
        if (noisy)
        begin
            s.stick_x = 8'($urandom);
            s.stick_y = 8'($urandom);
            s.c_button = 1'($urandom);
            s.z_button = 1'($urandom);
            s.time_ms = $urandom;
            return s;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: sample_clock += $urandom_range(0, hold_cfg / 2 + 1);
            6, 7, 8: sample_clock += 32'(int'(hold_cfg) + int'($urandom_range(0, 4)) - 2);
            default: sample_clock = $urandom;
        endcase
        // press at time zero now and then
        if ($urandom_range(0, 39) == 0)
            sample_clock = '0;
        if ($urandom_range(0, 3) == 0)
            held_combo = combo_t'($urandom_range(0, 3));
        m = int'(dz_cfg) + int'($urandom_range(0, 2)) - 1;
        case ($urandom_range(0, 3))
            0:
            begin
                a = int'($urandom_range(0, 255)) - 128;
                b = int'($urandom_range(0, 255)) - 128;
            end
            1:
            begin
                a = m;
                b = $urandom_range(0, 40);
            end
            2:
            begin
                a = $urandom_range(0, 128);
                b = a;
            end
            default:
            begin
                a = $urandom_range(0, 1) ? 127 : 128;
                b = ($urandom_range(0, 3) == 0) ? 128 : 0;
            end
        endcase
        if ($urandom_range(0, 1))
            a = -a;
        if ($urandom_range(0, 1))
            b = -b;
        if ($urandom_range(0, 1))
        begin
            t = a;
            a = b;
            b = t;
        end
        return mk(a, b, held_combo[0], held_combo[1], sample_clock);
    endfunction

    // offer one request, hold it until accepted, then maybe idle
    task automatic send(input sample_t s);
        in_data <= s;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (!source_steady && $urandom_range(0, 1) == 0)
        begin
            in_valid <= 1'b0;
            repeat (pick_gap()) @(posedge clk);
        end
    endtask

    // stop offering and wait for every predicted result to drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // register writes only while the pipeline is empty
    task automatic set_config(input logic [7:0] dz, input logic [15:0] hold);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_DEADZONE;
        cfg_data <= CFG_DATA_BITS'(dz);
        @(posedge clk);
        cfg_index <= CFG_HOLD_TIME;
        cfg_data <= hold;
        @(posedge clk);
        cfg_we <= 1'b0;
        dz_cfg = dz;
        hold_cfg = hold;
    endtask

    // receiver: random back pressure, steady stretches, and one long
    // hold-off counted here while the sender keeps pushing
    initial
    begin
        int gap_left;
        gap_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (gap_left > 0)
            begin
                out_ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!sink_steady && $urandom_range(0, 2) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    initial
    begin
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_DEADZONE;
        cfg_data = '0;
        rst_n = 1'b0;
        source_steady = 1'b0;
        sink_steady = 1'b0;
        hold_req = 1'b0;
        sample_clock = '0;
        held_combo = COMBO_NONE;
        dz_cfg = DEADZONE_RESET;
        hold_cfg = HOLD_TIME_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stick rails, ties and deadzone edge at reset settings
        send(mk(0, 0, 0, 0, 0));
        send(mk(127, 0, 0, 0, 10));
        send(mk(-128, 0, 0, 0, 20));
        send(mk(0, 127, 0, 0, 30));
        send(mk(0, -128, 0, 0, 40));
        send(mk(50, -50, 0, 0, 50));
        send(mk(20, 19, 0, 0, 60));
        send(mk(-19, 5, 0, 0, 70));
        // press at time zero never reads as held
        send(mk(0, 0, 1, 0, 0));
        send(mk(0, 0, 1, 0, 5000));
        // hold threshold: equal is not held, one more is
        send(mk(0, 0, 0, 1, 100));
        send(mk(0, 0, 0, 1, 1100));
        send(mk(0, 0, 0, 1, 1101));
        send(mk(0, 0, 1, 1, 2000));
        send(mk(0, 0, 1, 1, 3001));
        send(mk(0, 0, 1, 0, 3002));
        send(mk(0, 0, 0, 0, 3003));
        // stamp difference across the wrap
        send(mk(0, 0, 1, 0, 32'hFFFF_FF00));
        send(mk(0, 0, 1, 0, 32'h0000_0400));
        send(mk(0, 0, 0, 0, 32'h0000_0401));

        // zero deadzone, zero hold time
        set_config(8'd0, 16'd0);
        send(mk(0, 0, 0, 0, 1));
        send(mk(1, 0, 1, 0, 5));
        send(mk(0, -1, 1, 0, 6));
        // deadzone at the largest stick magnitude, longest hold
        set_config(8'd128, 16'd65535);
        send(mk(-128, 0, 0, 1, 10));
        send(mk(127, 0, 0, 1, 65545));
        send(mk(0, -128, 0, 1, 65546));

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_config(8'd0, 16'd0);
                1: set_config(8'd255, 16'd65535);
                2: set_config(8'd128, 16'd1);
                3: set_config(DEADZONE_RESET, HOLD_TIME_RESET);
                default: set_config(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                                 : 8'($urandom_range(0, 128)),
                                    ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                : 16'($urandom_range(0, 3000)));
            endcase
            // a couple of phases run with no idling on either side
            source_steady = (phase == 3 || phase == 6);
            sink_steady = (phase == 3 || phase == 6);
            for (int i = 0; i < 80; i++)
                send(next_sample($urandom_range(0, 7) == 0));
            if (phase == 2)
            begin
                // receiver stalls long while requests keep coming, so the
                // pipeline fills and in_ready drops
                source_steady = 1'b1;
                hold_req = 1'b1;
                repeat (24) send(next_sample(1'b0));
                source_steady = 1'b0;
            end
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
sv/jdbh_pkg.sv
sv/jdbh_dir.sv
sv/jdbh_btn.sv
sv/joystick_direction_button_hold_core.sv
dv/jdbh_result_check.sv
dv/tb_joystick_direction_button_hold_core.sv
